/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DRRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define DRRD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/drrd_pkg.sv */
// Types and constants shared by the read-reply deframer modules.
`timescale 1ns / 1ps

package drrd_pkg;

   // The byte count must reach a frame length of 255 + 3.
   localparam int CNT_W = 9;

   localparam logic [7:0] MIN_PAYLOAD     = 8'd6;
   localparam logic [8:0] HEAD_BYTES      = 9'd3;
   localparam logic [8:0] PAYLOAD_BASE    = 9'd4;
   localparam logic [8:0] FIRST_WORD_BYTE = 9'd7;

   // Fixed positions of the frame header bytes.
   localparam logic [8:0] POS_HEADER_FIRST  = 9'd0;
   localparam logic [8:0] POS_HEADER_SECOND = 9'd1;
   localparam logic [8:0] POS_PAYLOAD       = 9'd2;
   localparam logic [8:0] POS_COMMAND       = 9'd3;
   localparam logic [8:0] POS_START_HI      = 9'd4;
   localparam logic [8:0] POS_START_LO      = 9'd5;
   localparam logic [8:0] POS_WORDS         = 9'd6;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_FIRST       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SECOND      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_REPLY_COMMAND = 2'd2;

   localparam logic [7:0] HEADER_FIRST_RESET       = 8'h5A;
   localparam logic [7:0] HEADER_SECOND_RESET      = 8'hA5;
   localparam logic [7:0] READ_REPLY_COMMAND_RESET = 8'h83;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_READ_HI,
      ST_READ_LO,
      ST_LOAD,
      ST_SEND
   } drrd_state_type;

   typedef struct packed {
      logic take_byte;
      logic rd_lo;
      logic cap_hi;
      logic load_out;
      logic next_word;
   } drrd_cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic last_word;
   } drrd_status_type;

endpackage

/* hw/rtl/drrd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module drrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/drrd_ctrl.sv */
// Controller state machine: byte collection and per-word readout sequencing.
`timescale 1ns / 1ps

module drrd_ctrl import drrd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  drrd_status_type status,
   output drrd_cmd_type    cmd
);

   drrd_state_type state_ff;
   drrd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_stall     = 1'b0;
            cmd.take_byte = req_valid;
            if (req_valid && status.frame_ok) begin
               state_in = ST_READ_HI;
            end
         end
         ST_READ_HI: begin
            state_in = ST_READ_LO;
         end
         ST_READ_LO: begin
            cmd.rd_lo  = 1'b1;
            cmd.cap_hi = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_out = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.next_word = 1'b1;
               state_in      = status.last_word ? ST_COLLECT : ST_READ_HI;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

/* hw/rtl/drrd_datapath.sv */
// Datapath: byte counter, header capture, frame checks, frame RAM and output word.
`timescale 1ns / 1ps

module drrd_datapath import drrd_pkg::*; #(
   parameter int RX_BUFFER_BYTES = 64,
   parameter int MAX_WORDS       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  drrd_cmd_type           cmd,
   output drrd_status_type        status,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [15:0]            reg_address,
   output logic [15:0]            reg_value,
   output logic                   last_word
);

   localparam int AW = $clog2(RX_BUFFER_BYTES);
   localparam int IW = $clog2(MAX_WORDS + 1);
   localparam logic [CNT_W-1:0] BUF_LEN   = CNT_W'(RX_BUFFER_BYTES);
   localparam logic [7:0]       WORDS_MAX = 8'(MAX_WORDS);

   logic [7:0]       header_first_ff, header_second_ff, command_ff;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       hdr0_ff, hdr1_ff, payload_ff, cmd_byte_ff;
   logic [15:0]      start_ff;
   logic [7:0]       words_ff;
   logic [IW-1:0]    idx_ff;
   logic [7:0]       hi_ff;
   logic [15:0]      address_ff, value_ff;
   logic             last_ff;

   logic             full;
   logic             wr_en;
   logic [CNT_W-1:0] count_next;
   logic [7:0]       payload_now;
   logic [CNT_W-1:0] frame_len;
   logic             bad_len;
   logic             complete;
   logic             checks_ok;
   logic [CNT_W-1:0] rd_addr_full;
   logic [7:0]       rd_data;
   logic             is_last;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
         command_ff       <= READ_REPLY_COMMAND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HEADER_FIRST:       header_first_ff  <= csr_wdata;
            CSR_HEADER_SECOND:      header_second_ff <= csr_wdata;
            CSR_READ_REPLY_COMMAND: command_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      full        = (byte_count_ff >= BUF_LEN);
      wr_en       = cmd.take_byte && !full;
      count_next  = byte_count_ff + CNT_W'(1);
      payload_now = (byte_count_ff == POS_PAYLOAD) ? rx_byte : payload_ff;
      frame_len   = CNT_W'(payload_now) + HEAD_BYTES;
      // The length byte is judged once it is held, on every later byte too.
      bad_len     = (count_next >= HEAD_BYTES) &&
                    ((frame_len > BUF_LEN) || (payload_now < MIN_PAYLOAD));
      complete    = (count_next >= HEAD_BYTES) && (count_next == frame_len);
      checks_ok   = (hdr0_ff == header_first_ff) &&
                    (hdr1_ff == header_second_ff) &&
                    (cmd_byte_ff == command_ff) &&
                    (words_ff != 8'd0) && (words_ff <= WORDS_MAX) &&
                    (CNT_W'(payload_ff) == PAYLOAD_BASE + {words_ff, 1'b0});

      byte_count_in = byte_count_ff;
      if (cmd.take_byte) begin
         if (full || bad_len || complete) begin
            byte_count_in = '0;
         end else begin
            byte_count_in = count_next;
         end
      end

      status.frame_ok  = wr_en && !bad_len && complete && checks_ok;
      is_last          = ((8'(idx_ff) + 8'd1) == words_ff);
      status.last_word = is_last;

      rd_addr_full = FIRST_WORD_BYTE + CNT_W'({idx_ff, 1'b0}) + CNT_W'(cmd.rd_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         idx_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         if (cmd.take_byte) begin
            idx_ff <= '0;
         end else if (cmd.next_word) begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   // Header bytes sit at fixed places, so they are kept in registers as they arrive.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (byte_count_ff)
            POS_HEADER_FIRST:  hdr0_ff            <= rx_byte;
            POS_HEADER_SECOND: hdr1_ff            <= rx_byte;
            POS_PAYLOAD:       payload_ff         <= rx_byte;
            POS_COMMAND:       cmd_byte_ff        <= rx_byte;
            POS_START_HI:      start_ff[15:8]     <= rx_byte;
            POS_START_LO:      start_ff[7:0]      <= rx_byte;
            POS_WORDS:         words_ff           <= rx_byte;
            default: ;
         endcase
      end
      if (cmd.cap_hi) begin
         hi_ff <= rd_data;
      end
      if (cmd.load_out) begin
         address_ff <= start_ff + 16'(idx_ff);
         value_ff   <= {hi_ff, rd_data};
         last_ff    <= is_last;
      end
   end

   drrd_ram #(
      .WIDTH (8),
      .DEPTH (RX_BUFFER_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (byte_count_ff[AW-1:0]),
      .wr_data (rx_byte),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   assign reg_address = address_ff;
   assign reg_value   = value_ff;
   assign last_word   = last_ff;

endmodule

/* hw/rtl/display_read_reply_deframer.sv */
// Top level of the read-reply deframer: controller, datapath and ports.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one received serial byte per word (req_rx_byte).
// Bytes are taken one per cycle while the block is collecting a frame.
// When the byte that completes a valid read-reply frame is taken, req_stall
// rises and the block emits one rsp word per frame word: reg_address,
// reg_value and last_word, the last one flagged. A frame that fails its
// checks, or whose length byte is too small or too large, is dropped with
// no rsp word and collection restarts at once.
// After the final frame byte, or any rsp word but the last, is taken,
// the block steps through ST_READ_HI, ST_READ_LO and ST_LOAD to ST_SEND,
// where the next rsp word is valid; no byte is taken until the last word
// is taken. The two frame RAM reads per word set the pace. While rsp_stall
// is high the rsp word holds. Reset restores the header and command
// registers and empties the frame. csr_write/csr_index/csr_wdata write the
// three registers; the user must do so only when idle, as the block does not enforce it.

module display_read_reply_deframer import drrd_pkg::*; #(
   parameter int RX_BUFFER_BYTES = 64,
   parameter int MAX_WORDS       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_reg_address,
   output logic [15:0]            rsp_reg_value,
   output logic                   rsp_last_word,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   drrd_cmd_type    cmd;
   drrd_status_type status;

   drrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   drrd_datapath #(
      .RX_BUFFER_BYTES (RX_BUFFER_BYTES),
      .MAX_WORDS       (MAX_WORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rx_byte     (req_rx_byte),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .reg_address (rsp_reg_address),
      .reg_value   (rsp_reg_value),
      .last_word   (rsp_last_word)
   );

endmodule

/* hw/rtl/drrd_checker.sv */
// Port-level checker for the read-reply deframer and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_reg_address,
   input logic [15:0] rsp_reg_value,
   input logic        rsp_last_word
);

   // A stalled result word keeps its contents.
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reg_address) &&
         $stable(rsp_reg_value) && $stable(rsp_last_word);
   endproperty

   // Taking the last word of a frame ends the readout.
   property p_last_ends;
      rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid && !req_stall;
   endproperty

   `DRRD_ASSERT(a_rsp_hold, p_rsp_hold, "rsp word changed under stall")

   // No byte is taken while a frame is being read out.
   `DRRD_ASSERT(a_no_take_in_readout, rsp_valid |-> req_stall, "byte taken during readout")

   `DRRD_ASSERT(a_last_ends, p_last_ends, "readout continued after last word")

   `DRRD_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind display_read_reply_deframer drrd_checker u_drrd_checker (.*);
